// ----- rtl/rffba_pkg.sv -----
// Shared types and constants for the rotating first-fit bin assigner.
`default_nettype none
package rffba_pkg;

  localparam int LOAD_W  = 24;
  localparam int CUST_W  = 10;
  localparam int VEH_W   = 4;
  localparam int NVEH_W  = 5;
  localparam int CAP_W   = 16;
  localparam int CFG_W   = 16;
  localparam int ADDR_W  = 2;
  localparam int DATA_W  = 40;
  localparam int CMP_W   = 7;

  localparam logic [ADDR_W-1:0] REG_VEHICLES = 2'd0;
  localparam logic [ADDR_W-1:0] REG_CAPACITY = 2'd1;

  localparam logic MODE_CLEAR  = 1'b0;
  localparam logic MODE_ASSIGN = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_EVAL
  } state_t;

  // search chain passed from cell to cell
  typedef struct packed {
    logic              any_hi;
    logic              any_lo;
    logic [LOAD_W-1:0] sum;
  } chain_t;

endpackage
`default_nettype wire

// ----- rtl/rffba_cell.sv -----
// One vehicle cell: holds a load, checks fit, takes part in the priority chain.
`default_nettype none
module rffba_cell #(
  parameter int IDX = 0,
  parameter int IW  = 4
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          capture,
  input  wire [rffba_pkg::LOAD_W-1:0]  demand,
  input  wire [rffba_pkg::LOAD_W:0]    limit,
  input  wire                          elig_hi,
  input  wire                          elig_lo,
  input  wire                          commit,
  input  wire                          clear,
  input  wire                          hi_total,
  input  wire rffba_pkg::chain_t       chain_i,
  output rffba_pkg::chain_t            chain_o,
  input  wire [IW-1:0]                 idx_i,
  output logic [IW-1:0]                idx_o
);
  import rffba_pkg::*;

  localparam logic [IW-1:0] IDX_V = IW'(IDX);

  logic [LOAD_W-1:0] load_r;
  logic [LOAD_W-1:0] sum_r;
  logic              req_hi_r;
  logic              req_lo_r;
  logic [LOAD_W:0]   sum_w;
  logic              fit;
  logic              grant;

  assign sum_w = {1'b0, load_r} + {1'b0, demand};
  assign fit   = sum_w < limit;

  always_ff @(posedge clk) begin
    if (capture) begin
      sum_r    <= sum_w[LOAD_W-1:0];
      req_hi_r <= fit & elig_hi;
      req_lo_r <= fit & elig_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_r <= '0;
    end else if (clear) begin
      load_r <= '0;
    end else if (commit && grant) begin
      load_r <= sum_r;
    end
  end

  always_comb begin
    grant          = hi_total ? (req_hi_r & ~chain_i.any_hi) : (req_lo_r & ~chain_i.any_lo);
    chain_o.any_hi = chain_i.any_hi | req_hi_r;
    chain_o.any_lo = chain_i.any_lo | req_lo_r;
    chain_o.sum    = chain_i.sum | (grant ? sum_r : '0);
    idx_o          = idx_i | (grant ? IDX_V : '0);
  end

endmodule
`default_nettype wire

// ----- rtl/rotating_first_fit_bin_assigner.sv -----
// Top level: rotating-start first-fit vehicle assigner built from a row of cells.
// The result word is registered when evaluation ends, which waits until the output register is free.
// One word is taken at a time; its load update finishes before the next is taken.
// A waiting result does not block acceptance of the next input word; that word
// then holds in evaluation until the result is taken.
// Reset (rst_n low, synchronous) clears all loads and restores register defaults.
`default_nettype none
module rotating_first_fit_bin_assigner #(
  parameter int MAX_VEHICLES = 16
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_tvalid,
  output logic                           in_tready,
  // customer_id[9:0], demand[33:10], start_vehicle[37:34], zero fill
  input  wire [rffba_pkg::DATA_W-1:0]    in_tdata,
  // mode
  input  wire                            in_tuser,
  output logic                           out_tvalid,
  input  wire                            out_tready,
  // echo_customer[9:0], chosen_vehicle[13:10], updated_load[37:14], zero fill
  output logic [rffba_pkg::DATA_W-1:0]   out_tdata,
  // no_fit
  output logic                           out_tuser,
  input  wire                            cfg_we,
  input  wire [rffba_pkg::ADDR_W-1:0]    cfg_addr,
  input  wire [rffba_pkg::CFG_W-1:0]     cfg_wdata
);
  import rffba_pkg::*;

  localparam int IW = (MAX_VEHICLES > 1) ? $clog2(MAX_VEHICLES) : 1;
  localparam logic [CMP_W-1:0] MAXV = CMP_W'(MAX_VEHICLES);

  state_t state_r, state_nxt;

  logic [NVEH_W-1:0]   vehicles_r;
  logic [CAP_W-1:0]    capacity_r;
  logic                mode_r;
  logic [CUST_W-1:0]   cust_r;
  logic                out_valid_r;
  logic [DATA_W-1:0]   out_data_r;
  logic                out_user_r;

  logic                capture;
  logic                out_free;
  logic                done;
  logic                commit;
  logic                clear;
  logic [CUST_W-1:0]   in_cust;
  logic [LOAD_W-1:0]   in_demand;
  logic [VEH_W-1:0]    in_start;
  logic [CMP_W-1:0]    start_c;
  logic [CMP_W-1:0]    nveh_c;
  logic                start_ok;
  logic [LOAD_W:0]     limit;

  chain_t              chain [MAX_VEHICLES+1];
  logic [IW-1:0]       idx   [MAX_VEHICLES+1];
  logic                hi_total;

  assign in_cust   = in_tdata[CUST_W-1:0];
  assign in_demand = in_tdata[CUST_W+LOAD_W-1:CUST_W];
  assign in_start  = in_tdata[CUST_W+LOAD_W+VEH_W-1:CUST_W+LOAD_W];
  assign start_c   = CMP_W'(in_start);
  assign nveh_c    = CMP_W'(vehicles_r);
  assign start_ok  = (start_c < nveh_c) && (start_c < MAXV);
  assign limit     = {1'b0, capacity_r, 8'h00};

  assign in_tready = (state_r == ST_IDLE);
  assign capture   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign done      = (state_r == ST_EVAL) && out_free;
  assign commit    = done && (mode_r == MODE_ASSIGN);
  assign clear     = done && (mode_r == MODE_CLEAR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vehicles_r <= NVEH_W'(16);
      capacity_r <= '1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_VEHICLES: vehicles_r <= cfg_wdata[NVEH_W-1:0];
        REG_CAPACITY: capacity_r <= cfg_wdata[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (capture) state_nxt = ST_EVAL;
      ST_EVAL: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      mode_r <= in_tuser;
      cust_r <= in_cust;
    end
  end

  assign chain[0]   = '0;
  assign idx[0]     = '0;
  assign hi_total   = chain[MAX_VEHICLES].any_hi;

  for (genvar v = 0; v < MAX_VEHICLES; v++) begin : g_cell
    localparam logic [CMP_W-1:0] VI = CMP_W'(v);
    logic in_use;
    logic at_or_above;
    assign in_use      = VI < nveh_c;
    assign at_or_above = start_ok ? (VI >= start_c) : 1'b1;

    rffba_cell #(.IDX(v), .IW(IW)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .capture  (capture),
      .demand   (in_demand),
      .limit    (limit),
      .elig_hi  (in_use && at_or_above),
      .elig_lo  (in_use),
      .commit   (commit),
      .clear    (clear),
      .hi_total (hi_total),
      .chain_i  (chain[v]),
      .chain_o  (chain[v+1]),
      .idx_i    (idx[v]),
      .idx_o    (idx[v+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      if (mode_r == MODE_CLEAR) begin
        out_data_r <= '0;
        out_user_r <= 1'b0;
      end else begin
        out_data_r <= {(DATA_W-CUST_W-VEH_W-LOAD_W)'(0), chain[MAX_VEHICLES].sum,
                       VEH_W'(idx[MAX_VEHICLES]), cust_r};
        out_user_r <= ~chain[MAX_VEHICLES].any_lo;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
`default_nettype wire

// ----- rtl/rffba_checker.sv -----
// Port-level checks for the rotating first-fit bin assigner, bound to the top level.
`default_nettype none
module rffba_checker (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          in_tvalid,
  input wire                          in_tready,
  input wire                          out_tvalid,
  input wire                          out_tready,
  input wire [rffba_pkg::DATA_W-1:0]  out_tdata,
  input wire                          out_tuser
);
  import rffba_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  a_nofit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[CUST_W+VEH_W+LOAD_W-1:CUST_W] == '0)
    else $error("failed assign reports nonzero vehicle or load");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word taken before load update");

  a_result_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared without an evaluation cycle");

endmodule

bind rotating_first_fit_bin_assigner rffba_checker u_rffba_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire

// ----- bench/rotating_first_fit_bin_assigner_checker.sv -----
// Checker for the rotating first-fit bin assigner: tracks vehicle loads and compares each result word.
`timescale 1ns / 100ps
`default_nettype none
module rotating_first_fit_bin_assigner_checker (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_tvalid,
  input  wire                            in_tready,
  // customer_id[9:0], demand[33:10], start_vehicle[37:34], zero fill
  input  wire [rffba_pkg::DATA_W-1:0]    in_tdata,
  // mode
  input  wire                            in_tuser,
  input  wire                            out_tvalid,
  input  wire                            out_tready,
  // echo_customer[9:0], chosen_vehicle[13:10], updated_load[37:14], zero fill
  input  wire [rffba_pkg::DATA_W-1:0]    out_tdata,
  // no_fit
  input  wire                            out_tuser,
  input  wire                            cfg_we,
  input  wire [rffba_pkg::ADDR_W-1:0]    cfg_addr,
  input  wire [rffba_pkg::CFG_W-1:0]     cfg_wdata,
  output int                             fail_count,
  output int                             pending,
  output int                             placed_count,
  output int                             refused_count,
  output int                             clear_count
);
  import rffba_pkg::*;

  localparam int FLEET = 16;
  localparam int DUE_DEPTH = 8;

  typedef struct packed {
    logic [CUST_W-1:0] cust;
    logic [VEH_W-1:0]  veh;
    logic [LOAD_W-1:0] load;
    logic              no_fit;
  } placement_t;

  logic [LOAD_W-1:0] fleet_load [FLEET];
  logic [NVEH_W-1:0] fleet_size;
  logic [CAP_W-1:0]  cap_units;
  placement_t        due_ring [DUE_DEPTH];
  int                due_wr, due_rd;
  int                miscompares;
  int                placed, refused, cleared;

  task automatic place_customer(input logic mode, input logic [CUST_W-1:0] cust,
                                input logic [LOAD_W-1:0] dem, input logic [VEH_W-1:0] first,
                                output placement_t res);
    int          n, origin, slot;
    logic [31:0] total, ceiling;
    bit          found;
    res = '0;
    found = 0;
    if (mode == MODE_CLEAR) begin
      for (int v = 0; v < FLEET; v++) fleet_load[v] = '0;
      cleared++;
      return;
    end
    n = (fleet_size > FLEET) ? FLEET : int'(fleet_size);
    origin = (int'(first) >= n) ? 0 : int'(first);
    ceiling = {8'h00, cap_units, 8'h00};
    res.cust = cust;
    for (int k = 0; k < n && !found; k++) begin
      slot = (origin + k) % n;
      total = {8'h00, fleet_load[slot]} + {8'h00, dem};
      if (total < ceiling) begin
        found = 1;
        fleet_load[slot] = total[LOAD_W-1:0];
        res.veh = slot[VEH_W-1:0];
        res.load = total[LOAD_W-1:0];
      end
    end
    if (found) placed++;
    else begin
      res.no_fit = 1'b1;
      refused++;
    end
  endtask

  always @(posedge clk) begin
    placement_t got, due;
    if (!rst_n) begin
      for (int v = 0; v < FLEET; v++) fleet_load[v] = '0;
      fleet_size = 5'd16;
      cap_units = 16'hFFFF;
      due_wr = 0;
      due_rd = 0;
      miscompares = 0;
      placed = 0;
      refused = 0;
      cleared = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_VEHICLES: fleet_size = cfg_wdata[NVEH_W-1:0];
          REG_CAPACITY: cap_units = cfg_wdata[CAP_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.cust = out_tdata[9:0];
        got.veh = out_tdata[13:10];
        got.load = out_tdata[37:14];
        got.no_fit = out_tuser;
        if (due_wr == due_rd) begin
          miscompares++;
          $display("%0t: unexpected word: expected none, got cust=%0d veh=%0d load=%h no_fit=%b",
                   $time, got.cust, got.veh, got.load, got.no_fit);
        end else begin
          due = due_ring[due_rd % DUE_DEPTH];
          due_rd++;
          if (got.cust !== due.cust || got.veh !== due.veh || got.load !== due.load ||
              got.no_fit !== due.no_fit) begin
            miscompares++;
            $display("%0t: mismatch: expected cust=%0d veh=%0d load=%h no_fit=%b, %s",
                     $time, due.cust, due.veh, due.load, due.no_fit,
                     $sformatf("got cust=%0d veh=%0d load=%h no_fit=%b",
                               got.cust, got.veh, got.load, got.no_fit));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        place_customer(in_tuser, in_tdata[9:0], in_tdata[33:10], in_tdata[37:34], due);
        if (due_wr - due_rd >= DUE_DEPTH) begin
          miscompares++;
          $display("%0t: too many words outstanding: expected at most %0d, got %0d",
                   $time, DUE_DEPTH, due_wr - due_rd + 1);
        end else begin
          due_ring[due_wr % DUE_DEPTH] = due;
          due_wr++;
        end
      end
    end
    fail_count    <= miscompares;
    pending       <= due_wr - due_rd;
    placed_count  <= placed;
    refused_count <= refused;
    clear_count   <= cleared;
  end

endmodule
`default_nettype wire

// ----- bench/tb_rotating_first_fit_bin_assigner.sv -----
// Testbench top for the rotating first-fit bin assigner: stimulus, configuration and verdict.
`timescale 1ns / 100ps
`default_nettype none
module tb_rotating_first_fit_bin_assigner;
  import rffba_pkg::*;

  localparam logic [ADDR_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [ADDR_W-1:0] REG_SPARE_B = 2'd3;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 190;
  localparam int CALM_PHASE = 3;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata = '0;
  logic              in_tuser = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;
  logic              out_tuser;
  logic              cfg_we = 1'b0;
  logic [ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  bit                calm = 1'b0;
  int                cycles = 0;
  int                fail_count, pending, placed_count, refused_count, clear_count;
  int                settings_run = 1;

  always #1 clk = ~clk;

  rotating_first_fit_bin_assigner dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  rotating_first_fit_bin_assigner_checker placement_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending), .placed_count(placed_count),
    .refused_count(refused_count), .clear_count(clear_count)
  );

  always @(posedge clk) out_tready <= calm || ($urandom_range(99) >= 37);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, pending);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_word(input logic mode, input logic [CUST_W-1:0] cust,
                           input logic [LOAD_W-1:0] dem, input logic [VEH_W-1:0] first);
    while (!calm && $urandom_range(99) < 37) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= {2'b00, first, dem, cust};
    do @(posedge clk); while (!in_tready);
  endtask

  // drain everything outstanding so registers change only while idle
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [LOAD_W-1:0] pick_demand(input logic [CAP_W-1:0] cap);
    logic [31:0] lim;
    int unsigned r;
    lim = {8'h00, cap, 8'h00};
    r = $urandom_range(99);
    if (r < 8) return LOAD_W'($urandom());
    if (r < 12) return '0;
    if (lim == 0) return LOAD_W'($urandom_range(4095));
    if (r < 20) return LOAD_W'(lim - $urandom_range(2));
    return LOAD_W'($urandom_range(lim / $urandom_range(1, 6)));
  endfunction

  initial begin
    int unsigned fleet_plan [PHASES];
    int unsigned cap_plan [PHASES];
    logic [CFG_W-1:0] cap_now;
    fleet_plan = '{16, 1, 8, 5, 31, 3, 12, 0};
    cap_plan = '{65535, 1, 40, 300, 1000, 7, 65535, 500};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default settings: 16 vehicles, full capacity
    send_word(MODE_CLEAR, 10'h3FF, 24'hFFFFFF, 4'hF);
    send_word(MODE_ASSIGN, 10'd0, 24'h000000, 4'd0);
    send_word(MODE_ASSIGN, 10'd1023, 24'hFFFFFF, 4'd15);
    send_word(MODE_ASSIGN, 10'd5, 24'hFFFEFF, 4'd15);
    send_word(MODE_ASSIGN, 10'd6, 24'h000100, 4'd15);
    send_word(MODE_ASSIGN, 10'd7, 24'hAAAAAA, 4'd10);
    send_word(MODE_ASSIGN, 10'd8, 24'h555555, 4'd3);
    send_word(MODE_CLEAR, 10'd0, 24'h000000, 4'd0);
    settle();

    // spare indexes must be ignored
    write_reg(REG_SPARE_A, 16'h0001);
    write_reg(REG_SPARE_B, 16'hFFFF);
    write_reg(REG_VEHICLES, 16'd4);
    write_reg(REG_CAPACITY, 16'd20);
    send_word(MODE_ASSIGN, 10'd100, 24'h001000, 4'd9);
    for (int i = 0; i < 5; i++) send_word(MODE_ASSIGN, 10'(101 + i), 24'h001000, 4'd2);
    send_word(MODE_ASSIGN, 10'd110, 24'h0003FF, 4'd3);
    send_word(MODE_CLEAR, 10'd0, 24'h0, 4'd0);
    send_word(MODE_ASSIGN, 10'd111, 24'h0013FF, 4'd3);
    settle();

    write_reg(REG_VEHICLES, 16'd0);
    write_reg(REG_CAPACITY, 16'd100);
    send_word(MODE_ASSIGN, 10'd200, 24'h000001, 4'd0);
    send_word(MODE_ASSIGN, 10'd201, 24'h000000, 4'd7);
    settle();

    write_reg(REG_VEHICLES, 16'd31);
    write_reg(REG_CAPACITY, 16'd0);
    send_word(MODE_ASSIGN, 10'd300, 24'h000000, 4'd15);
    send_word(MODE_ASSIGN, 10'd301, 24'h000001, 4'd0);
    settle();

    write_reg(REG_VEHICLES, 16'd20);
    write_reg(REG_CAPACITY, 16'd1);
    send_word(MODE_ASSIGN, 10'd400, 24'h0000FF, 4'd7);
    send_word(MODE_ASSIGN, 10'd401, 24'h000100, 4'd7);
    settle();
    settings_run = 5;

    for (int p = 0; p < PHASES; p++) begin
      cap_now = CFG_W'(cap_plan[p]);
      write_reg(REG_VEHICLES, CFG_W'(fleet_plan[p]));
      write_reg(REG_CAPACITY, cap_now);
      settings_run++;
      calm <= (p == CALM_PHASE);
      send_word(MODE_CLEAR, 10'($urandom()), 24'($urandom()), 4'($urandom()));
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if ($urandom_range(99) < 5)
          send_word(MODE_CLEAR, 10'($urandom()), 24'($urandom()), 4'($urandom()));
        else
          send_word(MODE_ASSIGN, 10'($urandom_range(1023)), pick_demand(cap_now),
                    4'($urandom_range(15)));
      end
      settle();
    end

    calm <= 1'b0;
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
    $display("Ran %0d fleet/capacity settings: %0d customers placed, %0d refused, %0d clears.",
             settings_run, placed_count, refused_count, clear_count);
    $display("Mismatches seen: %0d.", fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
